// ===== src/source_text_tokenizer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the source text tokenizer.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define STT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define STT_ASSERT_SAME(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cause) |-> (effect)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define STT_ASSERT_NEXT(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cause) |=> (effect)) else $error(msg);

`endif

// ===== src/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants shared by the source text tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

   // Scanner modes.
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_COMMENT,
      MODE_DOTS,
      MODE_COLONS,
      MODE_SIGN,
      MODE_SYMBOL,
      MODE_DIGITS
   } scan_mode_type;

   // Token kinds.
   localparam logic [4:0] KIND_ERROR   = 5'd0;
   localparam logic [4:0] KIND_INT     = 5'd1;
   localparam logic [4:0] KIND_SYMBOL  = 5'd2;
   localparam logic [4:0] KIND_COEFF   = 5'd3;
   localparam logic [4:0] KIND_LPAREN  = 5'd4;
   localparam logic [4:0] KIND_RPAREN  = 5'd5;
   localparam logic [4:0] KIND_LBRACK  = 5'd6;
   localparam logic [4:0] KIND_RBRACK  = 5'd7;
   localparam logic [4:0] KIND_LBRACE  = 5'd8;
   localparam logic [4:0] KIND_RBRACE  = 5'd9;
   localparam logic [4:0] KIND_SEMI    = 5'd10;
   localparam logic [4:0] KIND_DOT     = 5'd11;
   localparam logic [4:0] KIND_COLON   = 5'd12;
   localparam logic [4:0] KIND_PIPE    = 5'd13;
   localparam logic [4:0] KIND_PLUS    = 5'd14;
   localparam logic [4:0] KIND_MINUS   = 5'd15;
   localparam logic [4:0] KIND_QUOTE   = 5'd16;
   localparam logic [4:0] KIND_NEWLINE = 5'd17;

   // Register indexes of the configuration port.
   localparam logic CSR_FIRST_LINE   = 1'b0;
   localparam logic CSR_FIRST_COLUMN = 1'b1;

   // Bytes with a special meaning.
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;

   // One token as it leaves the block, fields already clipped to 16 bits.
   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [15:0] length;
   } token_type;

endpackage

`default_nettype wire

// ===== src/source_text_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_core
// Byte-stream tokenizer with line and column tracking.
// ----------------------------------------------------------------------------
// The req channel carries one source byte per beat in req_tdata; req_tlast
// marks the last byte of a text and closes any token still open. The rsp
// channel carries one token per beat: kind in rsp_tuser, start line, start
// column and length in rsp_tdata, and rsp_tlast on the last token that a
// given byte produced. Bytes that complete no token produce no beat.
// The scanner state advances in the cycle a byte is accepted; the tokens it
// completes are registered into the result queue that drives rsp. A byte can
// be taken in every cycle while req_tready is high; one byte yields at most
// two tokens, and tokens drain at one per cycle from a four-entry result
// queue while rsp_tready is high. req_tready is high while the queue has
// room for two tokens, so a stalled receiver backs up into req once more
// than two tokens are waiting. Reset empties the queue, returns the scanner to
// idle and sets line and column to 1. The csr port writes the first line number
// (index 0) and first column number (index 1), each also presetting its counter;
// the user must write it only while no text is in flight; the block does not check it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "source_text_tokenizer_core_defines.svh"

module source_text_tokenizer_core
   import stt_pkg::*;
#(
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 16,
   parameter int LENGTH_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Source bytes.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tlast,   // end_of_input
   // Tokens.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [15:0] token_line, [31:16] token_column,
                                         // [47:32] token_length
   output logic [4:0]       rsp_tuser,   // [4:0] token_kind
   output logic             rsp_tlast,   // last_of_run
   // Configuration.
   input  wire logic        csr_wen,
   input  wire logic        csr_index,
   input  wire logic        csr_wdata
);

   localparam int QDEPTH = 4;
   localparam int QPTR   = $clog2(QDEPTH);

   typedef struct packed {
      token_type tok;
      logic      last;
   } entry_type;

   // Scanner state.
   scan_mode_type           mode_ff, mode_in;
   logic                    minus_ff, minus_in;
   logic [LENGTH_BITS-1:0]  run_len_ff, run_len_in;
   logic [LINE_BITS-1:0]    run_line_ff, run_line_in;
   logic [COLUMN_BITS-1:0]  run_col_ff, run_col_in;
   logic [LINE_BITS-1:0]    cur_line_ff, cur_line_in;
   logic [COLUMN_BITS-1:0]  cur_col_ff, cur_col_in;
   logic                    first_col_ff;

   // Result queue.
   entry_type               queue_ff [QDEPTH];
   logic [QPTR-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [QPTR:0]           count_ff, count_in;

   logic req_fire, rsp_fire;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // First step scans the byte itself.
   scan_mode_type          m1;
   logic                   s1_minus;
   logic [LENGTH_BITS-1:0] s1_len;
   logic [LINE_BITS-1:0]   s1_line, s1_cline;
   logic [COLUMN_BITS-1:0] s1_col, s1_ccol;
   logic [1:0]             n1;
   token_type              a0, a1;

   stt_scan #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_scan_byte (
      .mode_now      (mode_ff),
      .minus_now     (minus_ff),
      .run_len_now   (run_len_ff),
      .run_line_now  (run_line_ff),
      .run_col_now   (run_col_ff),
      .cur_line_now  (cur_line_ff),
      .cur_col_now   (cur_col_ff),
      .text_byte     (req_tdata),
      .first_col     (first_col_ff),
      .mode_next     (m1),
      .minus_next    (s1_minus),
      .run_len_next  (s1_len),
      .run_line_next (s1_line),
      .run_col_next  (s1_col),
      .cur_line_next (s1_cline),
      .cur_col_next  (s1_ccol),
      .emit_count    (n1),
      .emit0         (a0),
      .emit1         (a1)
   );

   // Second step closes an open token at the end of the text.
   scan_mode_type          m2;
   logic                   s2_minus;
   logic [LENGTH_BITS-1:0] s2_len;
   logic [LINE_BITS-1:0]   s2_line, s2_cline;
   logic [COLUMN_BITS-1:0] s2_col, s2_ccol;
   logic [1:0]             n2;
   token_type              b0, b1;

   stt_scan #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_scan_end (
      .mode_now      (m1),
      .minus_now     (s1_minus),
      .run_len_now   (s1_len),
      .run_line_now  (s1_line),
      .run_col_now   (s1_col),
      .cur_line_now  (s1_cline),
      .cur_col_now   (s1_ccol),
      .text_byte     (CHAR_NUL),
      .first_col     (first_col_ff),
      .mode_next     (m2),
      .minus_next    (s2_minus),
      .run_len_next  (s2_len),
      .run_line_next (s2_line),
      .run_col_next  (s2_col),
      .cur_line_next (s2_cline),
      .cur_col_next  (s2_ccol),
      .emit_count    (n2),
      .emit0         (b0),
      .emit1         (b1)
   );

   logic       end_step;
   logic [1:0] push_n;
   token_type  slot0, slot1;

   assign end_step = req_tlast && (req_tdata != CHAR_NUL);

   // Merge the two steps; together they never produce more than two tokens.
   always_comb begin
      push_n = n1;
      slot0  = a0;
      slot1  = a1;
      if (end_step) begin
         push_n = 2'(n1 + n2);
         if (n1 == 2'd0) begin
            slot0 = b0;
            slot1 = b1;
         end else if (n1 == 2'd1) begin
            slot1 = b0;
         end
      end
   end

   // Next scanner state.
   always_comb begin
      mode_in     = mode_ff;
      minus_in    = minus_ff;
      run_len_in  = run_len_ff;
      run_line_in = run_line_ff;
      run_col_in  = run_col_ff;
      cur_line_in = cur_line_ff;
      cur_col_in  = cur_col_ff;
      if (req_fire) begin
         mode_in     = end_step ? m2 : m1;
         minus_in    = end_step ? s2_minus : s1_minus;
         run_len_in  = end_step ? s2_len : s1_len;
         run_line_in = end_step ? s2_line : s1_line;
         run_col_in  = end_step ? s2_col : s1_col;
         cur_line_in = end_step ? s2_cline : s1_cline;
         cur_col_in  = end_step ? s2_ccol : s1_ccol;
      end
      if (csr_wen && csr_index == CSR_FIRST_LINE) begin
         cur_line_in = LINE_BITS'(csr_wdata);
      end
      if (csr_wen && csr_index == CSR_FIRST_COLUMN) begin
         cur_col_in = COLUMN_BITS'(csr_wdata);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (req_fire) begin
         count_in = count_in + (QPTR+1)'(push_n);
      end
      if (rsp_fire) begin
         count_in = count_in - (QPTR+1)'(1);
      end
   end

   // Control and scanner registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         minus_ff      <= 1'b0;
         run_len_ff    <= '0;
         run_line_ff   <= '0;
         run_col_ff    <= '0;
         cur_line_ff   <= LINE_BITS'(1);
         cur_col_ff    <= COLUMN_BITS'(1);
         first_col_ff  <= 1'b1;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         mode_ff     <= mode_in;
         minus_ff    <= minus_in;
         run_len_ff  <= run_len_in;
         run_line_ff <= run_line_in;
         run_col_ff  <= run_col_in;
         cur_line_ff <= cur_line_in;
         cur_col_ff  <= cur_col_in;
         count_ff    <= count_in;
         if (csr_wen && csr_index == CSR_FIRST_COLUMN) begin
            first_col_ff <= csr_wdata;
         end
         if (req_fire) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR'(push_n);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR'(1);
         end
      end
   end

   // Queue payload, no reset needed.
   always_ff @(posedge clock) begin
      if (req_fire && push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= '{slot0, push_n == 2'd1};
      end
      if (req_fire && push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + QPTR'(1)] <= '{slot1, 1'b1};
      end
   end

   // Handshakes and output payload.
   entry_type head;
   assign head       = queue_ff[rd_ptr_ff];
   assign req_tready = (count_ff <= (QPTR+1)'(QDEPTH - 2));
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {head.tok.length, head.tok.column, head.tok.line};
   assign rsp_tuser  = head.tok.kind;
   assign rsp_tlast  = head.last;

   // Checks.
   `STT_ASSERT_ALWAYS(a_queue_bound, count_ff <= (QPTR+1)'(QDEPTH),
      "result queue overfilled")
   `STT_ASSERT_NEXT(a_queue_count, req_fire && !rsp_fire,
      count_ff == $past(count_ff) + (QPTR+1)'($past(push_n)),
      "queue fill does not match tokens produced")
   `STT_ASSERT_NEXT(a_end_idle, req_fire && (req_tlast || req_tdata == CHAR_NUL),
      mode_ff == MODE_IDLE, "scanner not idle after end of text")
   `STT_ASSERT_SAME(a_run_open,
      mode_ff != MODE_IDLE && mode_ff != MODE_COMMENT, run_len_ff != '0,
      "open run with zero length")

endmodule

`default_nettype wire

// ===== src/stt_scan.sv =====
// ----------------------------------------------------------------------------
// stt_scan
// One scanning step: takes the scanner state and one byte, and returns the
// next state and the zero, one or two tokens that the byte completes.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_scan
   import stt_pkg::*;
#(
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 16,
   parameter int LENGTH_BITS = 16
) (
   input  wire scan_mode_type           mode_now,
   input  wire logic                    minus_now,
   input  wire logic [LENGTH_BITS-1:0]  run_len_now,
   input  wire logic [LINE_BITS-1:0]    run_line_now,
   input  wire logic [COLUMN_BITS-1:0]  run_col_now,
   input  wire logic [LINE_BITS-1:0]    cur_line_now,
   input  wire logic [COLUMN_BITS-1:0]  cur_col_now,
   input  wire logic [7:0]              text_byte,
   input  wire logic                    first_col,
   output scan_mode_type                mode_next,
   output logic                         minus_next,
   output logic [LENGTH_BITS-1:0]       run_len_next,
   output logic [LINE_BITS-1:0]         run_line_next,
   output logic [COLUMN_BITS-1:0]       run_col_next,
   output logic [LINE_BITS-1:0]         cur_line_next,
   output logic [COLUMN_BITS-1:0]       cur_col_next,
   output logic [1:0]                   emit_count,
   output token_type                    emit0,
   output token_type                    emit1
);

   // Character classes.
   function automatic logic [4:0] delim_kind(input logic [7:0] c);
      logic [4:0] k;
      unique case (c)
         8'h28:        k = KIND_LPAREN;
         8'h29:        k = KIND_RPAREN;
         8'h5B:        k = KIND_LBRACK;
         8'h5D:        k = KIND_RBRACK;
         8'h7B:        k = KIND_LBRACE;
         8'h7D:        k = KIND_RBRACE;
         8'h3B:        k = KIND_SEMI;
         CHAR_DOT:     k = KIND_DOT;
         CHAR_COLON:   k = KIND_COLON;
         8'h7C:        k = KIND_PIPE;
         CHAR_NEWLINE: k = KIND_NEWLINE;
         default:      k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic [15:0] clip16(input logic [31:0] v);
      return (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
   endfunction

   logic [7:0] c;
   logic [4:0] dk;
   logic       c_print, c_space, c_digit, c_alpha, c_symbol, c_symstart, c_symbolic;
   logic       c_zero;

   assign c          = text_byte;
   assign dk         = delim_kind(c);
   assign c_zero     = (c == CHAR_NUL);
   assign c_print    = (c >= 8'h20) && (c <= 8'h7E);
   assign c_space    = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   assign c_digit    = (c >= 8'h30) && (c <= 8'h39);
   assign c_alpha    = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   assign c_symbol   = c_print && (dk == KIND_ERROR) && !c_space;
   assign c_symstart = c_symbol && !c_digit && (c != CHAR_UNDER);
   assign c_symbolic = c_symstart && !c_alpha;

   // Clipped views of the run and of the current position.
   logic [15:0] run_len_out, run_line_out, run_col_out, cur_line_out, cur_col_out;

   assign run_len_out  = clip16(32'(run_len_now));
   assign run_line_out = clip16(32'(run_line_now));
   assign run_col_out  = clip16(32'(run_col_now));
   assign cur_line_out = clip16(32'(cur_line_now));
   assign cur_col_out  = clip16(32'(cur_col_now));

   // Decide, per mode, whether the byte extends the open run or closes it.
   logic          grow;
   logic          cons_only;
   logic          do_idle;
   logic          close_valid;
   token_type     close_tok;
   scan_mode_type mode_cont;

   always_comb begin
      grow        = 1'b0;
      cons_only   = 1'b0;
      do_idle     = 1'b0;
      close_valid = 1'b0;
      close_tok   = '0;
      mode_cont   = mode_now;
      unique case (mode_now)
         MODE_COMMENT: begin
            if (c == CHAR_NEWLINE || c_zero) begin
               do_idle = 1'b1;
            end else begin
               cons_only = 1'b1;
            end
         end
         MODE_DOTS: begin
            if (c == CHAR_DOT) begin
               grow = 1'b1;
            end else begin
               do_idle     = 1'b1;
               close_valid = 1'b1;
               close_tok   = '{(run_len_now > LENGTH_BITS'(1)) ? KIND_SYMBOL : KIND_DOT,
                               run_line_out, run_col_out, run_len_out};
            end
         end
         MODE_COLONS: begin
            if (c == CHAR_COLON) begin
               grow = 1'b1;
            end else begin
               do_idle     = 1'b1;
               close_valid = 1'b1;
               close_tok   = '{(run_len_now > LENGTH_BITS'(1)) ? KIND_SYMBOL :
                               (c_space ? KIND_COLON : KIND_QUOTE),
                               run_line_out, run_col_out, run_len_out};
            end
         end
         MODE_SIGN: begin
            // A sign stands alone unless a blank or a symbolic byte follows.
            if (!c_space && !c_symbolic) begin
               do_idle     = 1'b1;
               close_valid = 1'b1;
               close_tok   = '{minus_now ? KIND_MINUS : KIND_PLUS,
                               run_line_out, run_col_out, run_len_out};
            end else if (c_symbol) begin
               grow      = 1'b1;
               mode_cont = MODE_SYMBOL;
            end else begin
               do_idle     = 1'b1;
               close_valid = 1'b1;
               close_tok   = '{KIND_SYMBOL, run_line_out, run_col_out, run_len_out};
            end
         end
         MODE_SYMBOL: begin
            if (c_symbol) begin
               grow = 1'b1;
            end else begin
               do_idle     = 1'b1;
               close_valid = 1'b1;
               close_tok   = '{KIND_SYMBOL, run_line_out, run_col_out, run_len_out};
            end
         end
         MODE_DIGITS: begin
            if (c_digit) begin
               grow = 1'b1;
            end else begin
               do_idle     = 1'b1;
               close_valid = 1'b1;
               if (c_alpha) begin
                  close_tok = '{KIND_COEFF, run_line_out, run_col_out, run_len_out};
               end else if (dk != KIND_ERROR || c_space) begin
                  close_tok = '{KIND_INT, run_line_out, run_col_out, run_len_out};
               end else begin
                  // Bad byte after digits: empty error token at that byte.
                  close_tok = '{KIND_ERROR, cur_line_out, cur_col_out, 16'd0};
               end
            end
         end
         default: begin
            do_idle = 1'b1;
         end
      endcase
   end

   // Scan from idle, update the run and move the position.
   logic      idle_emit;
   token_type idle_tok;
   logic      do_consume;

   always_comb begin
      mode_next     = mode_cont;
      minus_next    = minus_now;
      run_len_next  = run_len_now;
      run_line_next = run_line_now;
      run_col_next  = run_col_now;
      cur_line_next = cur_line_now;
      cur_col_next  = cur_col_now;
      idle_emit     = 1'b0;
      idle_tok      = '0;

      if (grow && run_len_now != '1) begin
         run_len_next = run_len_now + LENGTH_BITS'(1);
      end

      if (do_idle) begin
         mode_next = MODE_IDLE;
         if (!c_zero) begin
            priority if (c == CHAR_HASH) begin
               mode_next = MODE_COMMENT;
            end else if (c == CHAR_DOT || c == CHAR_COLON || c_symstart || c_digit) begin
               run_len_next  = LENGTH_BITS'(1);
               run_line_next = cur_line_now;
               run_col_next  = cur_col_now;
               if (c == CHAR_DOT) begin
                  mode_next = MODE_DOTS;
               end else if (c == CHAR_COLON) begin
                  mode_next = MODE_COLONS;
               end else if (c_digit) begin
                  mode_next = MODE_DIGITS;
               end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                  mode_next  = MODE_SIGN;
                  minus_next = (c == CHAR_MINUS);
               end else begin
                  mode_next = MODE_SYMBOL;
               end
            end else if (dk != KIND_ERROR) begin
               idle_emit = 1'b1;
               idle_tok  = '{dk, cur_line_out, cur_col_out, 16'd1};
            end else if (!c_space) begin
               // Illegal byte or underscore: consumed as a one-byte error.
               idle_emit = 1'b1;
               idle_tok  = '{KIND_ERROR, cur_line_out, cur_col_out, 16'd1};
            end else begin
               idle_emit = 1'b0;
            end
         end
      end

      if (do_consume) begin
         if (c == CHAR_NEWLINE) begin
            if (cur_line_now != '1) begin
               cur_line_next = cur_line_now + LINE_BITS'(1);
            end
            cur_col_next = COLUMN_BITS'(first_col);
         end else if (cur_col_now != '1) begin
            cur_col_next = cur_col_now + COLUMN_BITS'(1);
         end
      end
   end

   assign do_consume = grow || cons_only || (do_idle && !c_zero);

   // Order the tokens: the closed run first, then the token that starts here.
   always_comb begin
      emit0      = '0;
      emit1      = '0;
      emit_count = 2'd0;
      if (close_valid) begin
         emit0 = close_tok;
         if (idle_emit) begin
            emit1      = idle_tok;
            emit_count = 2'd2;
         end else begin
            emit_count = 2'd1;
         end
      end else if (idle_emit) begin
         emit0      = idle_tok;
         emit_count = 2'd1;
      end
   end

endmodule

`default_nettype wire

// ===== verif/source_text_tokenizer_core_tb.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_core_tb
// Self-checking testbench for the byte-stream tokenizer. A directed table walks
// through token kinds and the corner cases of the scanner. Random text
// built from well-formed fragments with noise mixed in follows. The run covers
// four line/column settings and a long stall of the token sink. Every token
// beat is checked against an in-bench scanner model.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stt_pkg::*;

   localparam int HOLD_OFF_CYCLES = 80;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int PHASE_BYTES     = 50;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam string LETTERS   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   localparam string DIGITS    = "0123456789";
   localparam string DELIMS    = "()[]{};|";
   localparam string OP_START  = "!$%&*/<=>?@^~`',\"\\";
   localparam string WORD_BODY = "abcXYZqz0179!$%&*+-/<=>?@^~_#',\"\\";
   localparam string BAD_AFTER_DIGITS = "+-_$\"'!~#";

   // One expected token beat, with the flag that closes the byte's group.
   typedef struct packed {
      token_type token;
      logic      last;
   } token_beat_type;

   // One row of the directed table; typed rows carry a hand-written token.
   typedef struct packed {
      logic [7:0] text;
      logic       ends_text;
      logic       typed;
      token_type  token;
   } text_row_type;

   localparam token_type NO_TOKEN = '0;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] text_byte
   logic        req_tlast;   // end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // [15:0] line, [31:16] column, [47:32] length
   logic [4:0]  rsp_tuser;   // [4:0] token kind
   logic        rsp_tlast;
   logic        csr_wen;
   logic        csr_index;
   logic        csr_wdata;

   // Scanner model state.
   scan_mode_type scan_state;
   logic [15:0]   run_length;
   logic [15:0]   run_line;
   logic [15:0]   run_column;
   logic [15:0]   line_now;
   logic [15:0]   column_now;
   logic          minus_pending;
   logic          first_line_no;
   logic          first_column_no;

   token_type      step_tokens[$];
   token_beat_type pending_tokens[$];
   logic [8:0]     text_piece[$];   // {end of text, byte}

   int  mismatch_total = 0;
   int  bytes_sent     = 0;
   int  tokens_checked = 0;
   int  quiet_cycles   = 0;
   logic steady_flow   = 1'b0;
   logic hold_off_request = 1'b0;

   text_row_type directed_rows [31] = '{
      '{8'hFF, 1'b0, 1'b1, '{KIND_ERROR,  16'd1, 16'd1, 16'd1}},
      '{CHAR_UNDER, 1'b0, 1'b1, '{KIND_ERROR, 16'd1, 16'd2, 16'd1}},
      '{"(", 1'b0, 1'b1, '{KIND_LPAREN, 16'd1, 16'd3, 16'd1}},
      '{"[", 1'b0, 1'b0, NO_TOKEN},
      '{"{", 1'b0, 1'b0, NO_TOKEN},
      '{";", 1'b0, 1'b0, NO_TOKEN},
      '{"|", 1'b0, 1'b0, NO_TOKEN},
      '{"1", 1'b0, 1'b0, NO_TOKEN},
      '{"2", 1'b0, 1'b0, NO_TOKEN},
      '{"a", 1'b0, 1'b0, NO_TOKEN},
      '{" ", 1'b0, 1'b0, NO_TOKEN},
      '{"7", 1'b0, 1'b0, NO_TOKEN},
      '{"$", 1'b0, 1'b0, NO_TOKEN},
      '{CHAR_NEWLINE, 1'b0, 1'b0, NO_TOKEN},
      '{CHAR_COLON, 1'b0, 1'b0, NO_TOKEN},
      '{" ", 1'b0, 1'b0, NO_TOKEN},
      '{CHAR_COLON, 1'b0, 1'b0, NO_TOKEN},
      '{"x", 1'b0, 1'b0, NO_TOKEN},
      '{CHAR_DOT, 1'b0, 1'b0, NO_TOKEN},
      '{CHAR_DOT, 1'b0, 1'b0, NO_TOKEN},
      '{CHAR_MINUS, 1'b0, 1'b0, NO_TOKEN},
      '{CHAR_PLUS, 1'b1, 1'b0, NO_TOKEN},
      '{CHAR_HASH, 1'b0, 1'b0, NO_TOKEN},
      '{8'h80, 1'b0, 1'b0, NO_TOKEN},
      '{CHAR_NEWLINE, 1'b0, 1'b0, NO_TOKEN},
      '{CHAR_PLUS, 1'b0, 1'b0, NO_TOKEN},
      '{"5", 1'b0, 1'b0, NO_TOKEN},
      '{CHAR_NUL, 1'b0, 1'b0, NO_TOKEN},
      '{CHAR_COLON, 1'b1, 1'b0, NO_TOKEN},
      '{CHAR_MINUS, 1'b1, 1'b0, NO_TOKEN},
      '{"9", 1'b1, 1'b0, NO_TOKEN}
   };

   source_text_tokenizer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Byte classes of the scanner.
   // ------------------------------------------------------------------------
   function automatic logic is_printable(logic [7:0] c);
      return c >= 8'h20 && c <= 8'h7E;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [4:0] delimiter_kind(logic [7:0] c);
      case (c)
         "(":          return KIND_LPAREN;
         ")":          return KIND_RPAREN;
         "[":          return KIND_LBRACK;
         "]":          return KIND_RBRACK;
         "{":          return KIND_LBRACE;
         "}":          return KIND_RBRACE;
         ";":          return KIND_SEMI;
         CHAR_DOT:     return KIND_DOT;
         CHAR_COLON:   return KIND_COLON;
         "|":          return KIND_PIPE;
         CHAR_NEWLINE: return KIND_NEWLINE;
         default:      return KIND_ERROR;
      endcase
   endfunction

   function automatic logic is_symbol_char(logic [7:0] c);
      return is_printable(c) && delimiter_kind(c) == KIND_ERROR && !is_blank(c);
   endfunction

   function automatic logic is_word_start(logic [7:0] c);
      return is_symbol_char(c) && !is_digit(c) && c != CHAR_UNDER;
   endfunction

   function automatic logic is_operator_char(logic [7:0] c);
      return is_word_start(c) && !is_letter(c);
   endfunction

   // ------------------------------------------------------------------------
   // Scanner model: state updates and the tokens each byte closes.
   // ------------------------------------------------------------------------
   function automatic void reset_scanner();
      first_line_no   = 1'b1;
      first_column_no = 1'b1;
      scan_state      = MODE_IDLE;
      run_length      = '0;
      run_line        = '0;
      run_column      = '0;
      line_now        = 16'd1;
      column_now      = 16'd1;
      minus_pending   = 1'b0;
      pending_tokens.delete();
   endfunction

   function automatic void add_token(logic [4:0] kind, logic [15:0] line, logic [15:0] column,
                                     logic [15:0] length);
      token_type t;
      t.kind   = kind;
      t.line   = line;
      t.column = column;
      t.length = length;
      if (step_tokens.size() < 3) step_tokens.push_back(t);
   endfunction

   function automatic void close_run(logic [4:0] kind);
      add_token(kind, run_line, run_column, run_length);
   endfunction

   function automatic void advance_position(logic [7:0] c);
      if (c == CHAR_NEWLINE) begin
         if (line_now != COUNT_MAX) line_now++;
         column_now = 16'(first_column_no);
      end else if (column_now != COUNT_MAX) begin
         column_now++;
      end
   endfunction

   function automatic void open_run(scan_mode_type mode);
      scan_state = mode;
      run_length = 16'd1;
      run_line   = line_now;
      run_column = column_now;
   endfunction

   // Byte joins the open run.
   function automatic void absorb(logic [7:0] c);
      if (run_length != COUNT_MAX) run_length++;
      advance_position(c);
   endfunction

   function automatic void scan_fresh(logic [7:0] c);
      logic [4:0] k;
      scan_state = MODE_IDLE;
      if (c == CHAR_NUL) return;
      k = delimiter_kind(c);
      if (c == CHAR_HASH) scan_state = MODE_COMMENT;
      else if (c == CHAR_DOT) open_run(MODE_DOTS);
      else if (c == CHAR_COLON) open_run(MODE_COLONS);
      else if (k != KIND_ERROR) add_token(k, line_now, column_now, 16'd1);
      else if (is_word_start(c)) begin
         if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            open_run(MODE_SIGN);
            minus_pending = (c == CHAR_MINUS);
         end else begin
            open_run(MODE_SYMBOL);
         end
      end else if (is_digit(c)) begin
         open_run(MODE_DIGITS);
      end else if (!is_blank(c)) begin
         // Illegal byte at the start of a token is eaten and flagged.
         add_token(KIND_ERROR, line_now, column_now, 16'd1);
      end
      advance_position(c);
   endfunction

   function automatic void scan_next(logic [7:0] c);
      case (scan_state)
         MODE_COMMENT: begin
            if (c == CHAR_NEWLINE || c == CHAR_NUL) scan_fresh(c);
            else advance_position(c);
            return;
         end
         MODE_DOTS: begin
            if (c == CHAR_DOT) begin
               absorb(c);
               return;
            end
            close_run(run_length > 1 ? KIND_SYMBOL : KIND_DOT);
         end
         MODE_COLONS: begin
            if (c == CHAR_COLON) begin
               absorb(c);
               return;
            end
            if (run_length > 1) close_run(KIND_SYMBOL);
            else close_run(is_blank(c) ? KIND_COLON : KIND_QUOTE);
         end
         MODE_SIGN: begin
            // A sign stays alone unless a blank or an operator byte follows.
            if (!is_blank(c) && !is_operator_char(c)) begin
               close_run(minus_pending ? KIND_MINUS : KIND_PLUS);
            end else begin
               scan_state = MODE_SYMBOL;
               if (is_symbol_char(c)) begin
                  absorb(c);
                  return;
               end
               close_run(KIND_SYMBOL);
            end
         end
         MODE_SYMBOL: begin
            if (is_symbol_char(c)) begin
               absorb(c);
               return;
            end
            close_run(KIND_SYMBOL);
         end
         MODE_DIGITS: begin
            if (is_digit(c)) begin
               absorb(c);
               return;
            end
            if (is_letter(c)) close_run(KIND_COEFF);
            else if (delimiter_kind(c) != KIND_ERROR || is_blank(c)) close_run(KIND_INT);
            else add_token(KIND_ERROR, line_now, column_now, 16'd0);
         end
         default: ;
      endcase
      scan_fresh(c);
   endfunction

   // Predicts the token beats caused by one accepted byte.
   function automatic void tokenize_byte(logic [7:0] c, logic ends_text);
      token_beat_type beat;
      step_tokens.delete();
      scan_next(c);
      if (ends_text && c != CHAR_NUL) scan_next(CHAR_NUL);
      foreach (step_tokens[i]) begin
         beat.token = step_tokens[i];
         beat.last  = (i == step_tokens.size() - 1);
         pending_tokens.push_back(beat);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Random text built from fragments.
   // ------------------------------------------------------------------------
   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 5))
         0: return 8'h09;
         1: return 8'h0B;
         2: return 8'h0C;
         3: return 8'h0D;
         default: return 8'h20;
      endcase
   endfunction

   function automatic void put(logic [7:0] c);
      text_piece.push_back({1'b0, c});
   endfunction

   function automatic void build_fragment();
      logic [7:0] c;
      int         n;
      text_piece.delete();
      case ($urandom_range(0, 19))
         0, 1, 2, 3: begin
            put($urandom_range(0, 3) == 0 ? pick(OP_START) : pick(LETTERS));
            repeat ($urandom_range(0, 6)) put(pick(WORD_BODY));
         end
         4, 5, 6: repeat ($urandom_range(1, 5)) put(pick(DIGITS));
         7: begin
            repeat ($urandom_range(1, 3)) put(pick(DIGITS));
            put(pick(LETTERS));
            repeat ($urandom_range(0, 3)) put(pick(WORD_BODY));
         end
         8: begin
            // Digits closed by a byte that cannot end a number.
            repeat ($urandom_range(1, 3)) put(pick(DIGITS));
            case ($urandom_range(0, 2))
               0: put(pick(BAD_AFTER_DIGITS));
               1: put(8'($urandom_range(128, 255)));
               default: put(CHAR_NUL);
            endcase
         end
         9: repeat ($urandom_range(1, 3)) put(CHAR_DOT);
         10: begin
            repeat ($urandom_range(1, 3)) put(CHAR_COLON);
            case ($urandom_range(0, 3))
               0: put(pick_blank());
               1: put(pick(LETTERS));
               2: put(pick(DIGITS));
               default: ;
            endcase
         end
         11: begin
            put($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
            case ($urandom_range(0, 4))
               0: put(pick(DIGITS));
               1: put(pick_blank());
               2: put(pick(OP_START));
               3: put(pick(LETTERS));
               default: put(pick(DELIMS));
            endcase
         end
         12, 13, 14: put(pick(DELIMS));
         15: begin
            // Comment body may hold any byte but newline and zero.
            put(CHAR_HASH);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
               c = 8'($urandom_range(1, 255));
               put(c == CHAR_NEWLINE ? CHAR_HASH : c);
            end
            put(CHAR_NEWLINE);
         end
         16: put(CHAR_NEWLINE);
         17: repeat ($urandom_range(1, 3)) put(pick_blank());
         18: repeat ($urandom_range(1, 2)) put(8'($urandom_range(0, 255)));
         default: put(CHAR_NUL);
      endcase
      if ($urandom_range(0, 1) == 0) put(pick_blank());
      if ($urandom_range(0, 15) == 0) text_piece[text_piece.size() - 1][8] = 1'b1;
   endfunction

   function automatic int sender_gap();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 9);
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int stall_length();
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Source side.
   // ------------------------------------------------------------------------
   task automatic send_byte(logic [7:0] c, logic ends_text);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= ends_text;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tokenize_byte(c, ends_text);
      bytes_sent++;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_text(int count);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         if ($urandom_range(0, 7) == 0) steady_flow = !steady_flow;
         build_fragment();
         foreach (text_piece[i]) send_byte(text_piece[i][7:0], text_piece[i][8]);
      end
      // End the text so no token stays open across a register write.
      send_byte(" ", 1'b1);
      steady_flow = 1'b0;
   endtask

   // Registers are written only once every token is out and the block is quiet.
   task automatic write_config(logic line_first, logic column_first);
      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= CSR_FIRST_LINE;
      csr_wdata <= line_first;
      @(posedge clock);
      first_line_no = line_first;
      line_now      = 16'(line_first);
      csr_index <= CSR_FIRST_COLUMN;
      csr_wdata <= column_first;
      @(posedge clock);
      first_column_no = column_first;
      column_now      = 16'(column_first);
      csr_wen <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Token sink: random stalls, plus one long hold-off on request.
   // ------------------------------------------------------------------------
   initial begin : token_sink
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (stall_length()) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Token checker.
   // ------------------------------------------------------------------------
   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: token %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_total++;
      end
   endfunction

   always @(posedge clock) begin : check_tokens
      token_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tokens.size() == 0) begin
            $display("%0t: unexpected token beat, expected none, actual kind %0d line %0d",
                     $time, rsp_tuser, rsp_tdata[15:0]);
            mismatch_total++;
         end else begin
            want = pending_tokens.pop_front();
            compare_field("kind", 16'(want.token.kind), 16'(rsp_tuser));
            compare_field("line", want.token.line, rsp_tdata[15:0]);
            compare_field("column", want.token.column, rsp_tdata[31:16]);
            compare_field("length", want.token.length, rsp_tdata[47:32]);
            compare_field("last", 16'(want.last), 16'(rsp_tlast));
            tokens_checked++;
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_wen    = 1'b0;
      csr_index  = CSR_FIRST_LINE;
      csr_wdata  = 1'b0;
      reset_scanner();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table; typed rows pin the model to hand-written tokens.
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].text, directed_rows[i].ends_text);
         if (directed_rows[i].typed &&
             (step_tokens.size() != 1 || step_tokens[0] != directed_rows[i].token)) begin
            $display("%0t: directed row %0d, expected token %h, actual model output %0d tokens",
                     $time, i, directed_rows[i].token, step_tokens.size());
            mismatch_total++;
         end
      end

      // Random text under each line/column setting.
      write_config(1'b0, 1'b0);
      random_text(PHASE_BYTES);
      write_config(1'b1, 1'b0);
      random_text(PHASE_BYTES);
      write_config(1'b0, 1'b1);
      random_text(PHASE_BYTES);

      // Back to the reset setting; a long sink hold-off while bytes keep coming.
      write_config(1'b1, 1'b1);
      hold_off_request = 1'b1;
      steady_flow      = 1'b1;
      repeat (40) send_byte(pick(DELIMS), 1'b0);
      steady_flow = 1'b0;
      random_text(PHASE_BYTES);

      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Summary: %0d source bytes, %0d token beats checked, %0d mismatches.",
               bytes_sent, tokens_checked, mismatch_total);
      $display("Ran four line/column settings and a long sink hold-off with the input backed up.");
      if (mismatch_total == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
